/* src/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds at a clock edge, cons must hold too.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication: when ante holds, cons must hold at the following edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* src/tqp_pkg.sv */
package tqp_pkg;

   // Number of thresholds the quantizer may consult (1 to 15).
   localparam int ThresholdCount = 15;
   // Threshold storage is fixed by the register map: 8 low plus 7 high bytes.
   localparam int ThreshSlots = 15;

   localparam int CsrAddrWidth = 2;
   localparam int CsrDataWidth = 64;

   // Register indexes on the configuration port.
   localparam logic [CsrAddrWidth-1:0] CsrPixelWidth = 2'd0;
   localparam logic [CsrAddrWidth-1:0] CsrThreshLow  = 2'd1;
   localparam logic [CsrAddrWidth-1:0] CsrThreshHigh = 2'd2;

   // Pixel width codes. Any other code selects four-bit codes.
   localparam logic [1:0] WidthOne  = 2'd0;
   localparam logic [1:0] WidthTwo  = 2'd1;
   localparam logic [1:0] WidthFour = 2'd2;

   localparam logic [7:0]  PartialReset    = 8'hFF;
   localparam logic [63:0] ThreshLowReset  = 64'hFFFF_FFFF_FFFF_FF7D;
   localparam logic [55:0] ThreshHighReset = 56'hFF_FFFF_FFFF_FFFF;

   typedef logic [ThreshSlots-1:0][7:0] thresh_array_type;

endpackage

/* src/threshold_quantize_pack_core.sv */
// Threshold quantizer and bit packer for an 8-bit gray pixel stream.
// The req channel carries one pixel per transaction in raster order, with
// req_tlast marking the last pixel of an image row. Each pixel is turned into
// a 1, 2 or 4-bit code by comparing it against the configured thresholds, and
// the codes are packed MSB-first into bytes that start as all ones.
// The rsp channel carries one packed byte per transaction when the byte is
// full or the row ends; rsp_tlast marks the last byte of a row and slots that
// were never filled read as ones.
// A pixel is taken into an input register, quantized and packed from there,
// and its byte lands in the output register, which drives rsp_tvalid; a
// byte waiting there on a stalled receiver can hold the packing step back.
// One pixel is accepted in every cycle unless a byte-completing pixel is held
// behind a stalled output byte; the packing state update is the only loop.
// When the receiver stalls, the byte waits in the output register while the
// input register still takes one more pixel; pixels that do not complete a
// byte keep flowing. Synchronous reset empties both registers, restores the
// default thresholds and one-bit mode, and starts a fresh byte. Users must write
// configuration via csr_we/csr_addr/csr_wdata only while idle; not enforced.
module threshold_quantize_pack_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic                           [7:0] req_tdata,   // [7:0] gray_level
   input  logic                                 req_tlast,   // last_in_row
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic                           [7:0] rsp_tdata,   // [7:0] packed_byte
   output logic                                 rsp_tlast,   // row_end
   input  logic                                 csr_we,
   input  logic    [tqp_pkg::CsrAddrWidth-1:0]  csr_addr,
   input  logic    [tqp_pkg::CsrDataWidth-1:0]  csr_wdata
);
   import tqp_pkg::*;

   // Configuration registers.
   logic [1:0]  width_ff;
   logic [63:0] thr_low_ff;
   logic [55:0] thr_high_ff;

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_gray_ff;
   logic       in_last_ff;

   // Packing state.
   logic [7:0] partial_ff, partial_in;
   logic [2:0] slot_ff, slot_in;

   // Output register.
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff;
   logic       out_last_ff;

   thresh_array_type thresholds;
   logic [3:0] code;
   logic [7:0] ones;
   logic [3:0] per_byte;
   logic [2:0] shift;
   logic [7:0] field_mask;
   logic [7:0] merged;
   logic       place;
   logic       emit;
   logic       advance;
   logic       accept;

   assign thresholds = thresh_array_type'({thr_high_ff, thr_low_ff});

   tqp_quantize u_quantize (
      .width_code (width_ff),
      .gray_level (in_gray_ff),
      .thresholds (thresholds),
      .code       (code)
   );

   // Field geometry for the current slot. The shift is only used when the
   // slot still lies inside the byte.
   always_comb begin
      case (width_ff)
         WidthOne: begin
            ones     = 8'h01;
            per_byte = 4'd8;
            shift    = 3'd7 - slot_ff;
         end
         WidthTwo: begin
            ones     = 8'h03;
            per_byte = 4'd4;
            shift    = 3'd6 - {slot_ff[1:0], 1'b0};
         end
         default: begin
            ones     = 8'h0F;
            per_byte = 4'd2;
            shift    = 3'd4 - {slot_ff[0], 2'b00};
         end
      endcase
   end

   // A slot beyond the byte (after a width change mid-byte) drops the code
   // and flushes what has been collected so far.
   always_comb begin
      place      = {1'b0, slot_ff} < per_byte;
      field_mask = ones << shift;
      merged     = place ? ((partial_ff & ~field_mask) | ((8'(code) << shift) & field_mask))
                         : partial_ff;
      emit       = (({1'b0, slot_ff} + 4'd1) >= per_byte) || in_last_ff;
   end

   // The held pixel moves on unless it produces a byte that has nowhere to go.
   assign advance    = in_valid_ff && (!emit || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      partial_in   = partial_ff;
      slot_in      = slot_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (advance) begin
         if (emit) begin
            partial_in   = PartialReset;
            slot_in      = 3'd0;
            out_valid_in = 1'b1;
         end else begin
            partial_in = merged;
            slot_in    = slot_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WidthOne;
         thr_low_ff   <= ThreshLowReset;
         thr_high_ff  <= ThreshHighReset;
         in_valid_ff  <= 1'b0;
         partial_ff   <= PartialReset;
         slot_ff      <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CsrPixelWidth: width_ff    <= csr_wdata[1:0];
               CsrThreshLow:  thr_low_ff  <= csr_wdata[63:0];
               CsrThreshHigh: thr_high_ff <= csr_wdata[55:0];
               default:       ;
            endcase
         end
         in_valid_ff  <= in_valid_in;
         partial_ff   <= partial_in;
         slot_ff      <= slot_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_gray_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && emit) begin
         out_byte_ff <= merged;
         out_last_ff <= in_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

/* src/tqp_quantize.sv */
module tqp_quantize (
   input  logic                      [1:0] width_code,
   input  logic                      [7:0] gray_level,
   input  tqp_pkg::thresh_array_type       thresholds,
   output logic                      [3:0] code
);
   import tqp_pkg::*;

   logic [3:0] count;

   always_comb begin
      case (width_code)
         WidthOne: count = 4'd1;
         WidthTwo: count = 4'd3;
         default:  count = 4'd15;
      endcase
      if (count > 4'(ThresholdCount)) begin
         count = 4'(ThresholdCount);
      end
   end

   // The first threshold in use (lowest index) that lies above the pixel gives the code.
   always_comb begin
      code = count;
      for (int k = ThreshSlots - 1; k >= 0; k--) begin
         if ((4'(k) < count) && (gray_level < thresholds[k])) begin
            code = 4'(k);
         end
      end
   end

endmodule

/* src/tqp_checker.sv */
`include "assert_macros.svh"

module tqp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // A stalled byte stays put until it is taken.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // Reset leaves no byte on the output.
   `ASSERT_NEXT(a_rsp_reset, clock, 1'b0, reset, !rsp_tvalid)

   // With the output empty, the input side never pushes back.
   `ASSERT_IMPLY(a_req_open, clock, reset, !rsp_tvalid, req_tready)

   // A byte only appears once a pixel transaction has passed the input register.
   `ASSERT_IMPLY(a_rsp_cause, clock, reset, $rose(rsp_tvalid),
                 $past(req_tvalid && req_tready, 2))

endmodule

bind threshold_quantize_pack_core tqp_checker u_tqp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
